FILE: rtl/core/css_pkg.sv
package css_pkg;

    localparam int unsigned DEPTH_DEF      = 64;
    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned FIELD_W        = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sorted_value;
        logic                      final_res;
        logic                      dropped;
    } t_out_item;

endpackage

FILE: rtl/core/css_ram.sv
module css_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cocktail_shaker_sort_unit.sv
// load: one input transaction per cycle; the batch closes on the transaction marked last
// sort: one compare-swap per cycle through the element ram
// unload: each output transaction is a ram read, then the output register; it holds under i_out_stall
// reset: synchronous active low, clears state, counters and output valid; ram is not cleared
module cocktail_shaker_sort_unit
    import css_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    // output channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned KW = AW + 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_LR_FIRST,
        S_LR_CARRY,
        S_LR_CMP,
        S_LR_END,
        S_RL_FIRST,
        S_RL_CARRY,
        S_RL_CMP,
        S_RL_END,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    // control state
    t_state          r_state,     n_state;
    logic [CW-1:0]   r_count,     n_count;
    logic            r_ovf,       n_ovf;
    logic [AW-1:0]   r_left,      n_left;
    logic [AW-1:0]   r_right,     n_right;
    logic [AW-1:0]   r_k,         n_k;
    logic [AW-1:0]   r_mark,      n_mark;
    logic            r_swp,       n_swp;
    logic            r_out_valid, n_out_valid;
    // payload
    logic [DATA_WIDTH-1:0] r_carry, n_carry;
    t_out_item             r_out,   n_out;

    // ram ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  has_room;
    logic [CW-1:0]         count_after;
    logic [DATA_WIDTH-1:0] in_word;
    logic                  last_k;

    css_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // input word is the raw 32-bit pattern, truncated or zero extended
    assign in_word     = DATA_WIDTH'($unsigned(i_in.value));
    assign has_room    = (r_count < CW'(DEPTH));
    assign count_after = has_room ? (r_count + CW'(1)) : r_count;
    assign last_k      = ((KW'(r_k) + KW'(1)) == KW'(r_count));

    // input side only open while collecting a batch
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_left      = r_left;
        n_right     = r_right;
        n_k         = r_k;
        n_mark      = r_mark;
        n_swp       = r_swp;
        n_out_valid = r_out_valid;
        n_carry     = r_carry;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_k;
        ram_wdata   = r_carry;
        ram_raddr   = r_k;

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (has_room) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_count);
                        ram_wdata = in_word;
                        n_count   = count_after;
                    end else begin
                        // beyond capacity: discard, flag the batch
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_left  = '0;
                        n_right = AW'(count_after - CW'(1));
                        n_state = S_LR_FIRST;
                    end
                end
            end

            // left to right: the larger value travels in r_carry
            S_LR_FIRST: begin
                ram_raddr = r_left;
                n_k       = r_left;
                if (r_left < r_right) begin
                    n_state = S_LR_CARRY;
                end else begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_LR_CARRY: begin
                n_carry   = ram_rdata;
                ram_raddr = r_k + AW'(1);
                n_swp     = 1'b0;
                n_mark    = r_right;
                n_state   = S_LR_CMP;
            end
            S_LR_CMP: begin
                // read ahead two slots, write back the one just passed
                ram_raddr = r_k + AW'(2);
                ram_we    = 1'b1;
                ram_waddr = r_k;
                if ($signed(r_carry) > $signed(ram_rdata)) begin
                    ram_wdata = ram_rdata;
                    n_swp     = 1'b1;
                    n_mark    = r_k;
                end else begin
                    // carried word settles here, the neighbor travels on
                    ram_wdata = r_carry;
                    n_carry   = ram_rdata;
                end
                if ((r_k + AW'(1)) == r_right) begin
                    n_state = S_LR_END;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            S_LR_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_right;
                ram_wdata = r_carry;
                if (r_swp) begin
                    n_right = r_mark;
                    n_state = S_RL_FIRST;
                end else begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end
            end

            // right to left: the smaller value travels in r_carry
            S_RL_FIRST: begin
                ram_raddr = r_right;
                n_k       = r_right;
                if (r_right > r_left) begin
                    n_state = S_RL_CARRY;
                end else begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_RL_CARRY: begin
                n_carry   = ram_rdata;
                ram_raddr = r_k - AW'(1);
                n_swp     = 1'b0;
                n_mark    = r_left;
                n_state   = S_RL_CMP;
            end
            S_RL_CMP: begin
                ram_raddr = r_k - AW'(2);
                ram_we    = 1'b1;
                ram_waddr = r_k;
                if ($signed(ram_rdata) > $signed(r_carry)) begin
                    ram_wdata = ram_rdata;
                    n_swp     = 1'b1;
                    n_mark    = r_k;
                end else begin
                    ram_wdata = r_carry;
                    n_carry   = ram_rdata;
                end
                if ((r_k - AW'(1)) == r_left) begin
                    n_state = S_RL_END;
                end else begin
                    n_k = r_k - AW'(1);
                end
            end
            S_RL_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_left;
                ram_wdata = r_carry;
                if (r_swp) begin
                    n_left  = r_mark;
                    n_state = S_LR_FIRST;
                end else begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end
            end

            // unload in address order
            S_OUT_RD: begin
                ram_raddr = r_k;
                n_state   = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out.sorted_value = FIELD_W'(ram_rdata);
                n_out.final_res    = last_k;
                n_out.dropped      = r_ovf;
                n_out_valid        = 1'b1;
                n_state            = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                // next address presented so the ram has it at the accepting edge
                ram_raddr = r_k + AW'(1);
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out.final_res) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_OUT_LD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_left      <= '0;
            r_right     <= '0;
            r_k         <= '0;
            r_mark      <= '0;
            r_swp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_left      <= n_left;
            r_right     <= n_right;
            r_k         <= n_k;
            r_mark      <= n_mark;
            r_swp       <= n_swp;
            r_out_valid <= n_out_valid;
        end
        r_carry <= n_carry;
        r_out   <= n_out;
    end

endmodule

FILE: rtl/core/css_checker.sv
module css_checker
    import css_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output transaction changed under stall");

    // no input taken while results are being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while output valid");

    // closing transaction stops the input side
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.last |=> o_in_stall)
        else $error("input open after batch close");

    // nothing follows the final result
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out.final_res |=> !o_out_valid && !o_in_stall)
        else $error("activity after final result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind cocktail_shaker_sort_unit css_checker u_css_checker (.*);
